[sv/srt_pkg.sv]
// Shared types and constants of the sorted range table.
package srt_pkg;

    // Table geometry and field widths
    localparam int CAPACITY    = 64;
    localparam int OFFSET_BITS = 32;
    localparam int HANDLE_BITS = 16;
    localparam int COUNT_BITS  = $clog2(CAPACITY + 1);
    localparam int IDX_BITS    = $clog2(CAPACITY);

    // Request kinds
    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_FIND   = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_kind_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_NONE = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_PREP,
        S_SHIFT,
        S_PLACE,
        S_DONE
    } state_t;

    // Request beat
    typedef struct packed {
        req_kind_t               req_type;
        logic [OFFSET_BITS-1:0]  req_start;
        logic [OFFSET_BITS-1:0]  req_length;
        logic [HANDLE_BITS-1:0]  req_handle;
    } req_t;

    // Result beat
    typedef struct packed {
        status_t                 status;
        logic [HANDLE_BITS-1:0]  found_handle;
        logic [OFFSET_BITS-1:0]  found_start;
        logic [OFFSET_BITS-1:0]  found_length;
        logic [COUNT_BITS-1:0]   entry_count;
    } rsp_t;

    // One stored table entry
    typedef struct packed {
        logic [OFFSET_BITS-1:0]  start;
        logic [OFFSET_BITS-1:0]  length;
        logic [HANDLE_BITS-1:0]  handle;
    } entry_t;

    // Flags from the entry comparator
    typedef struct packed {
        logic ahead;    // entry orders strictly ahead of the key
        logic exact;    // same start and length
        logic past;     // entry starts after the key start
        logic covers;   // entry spans the whole key range
    } cmp_t;

endpackage

[sv/sorted_range_table_unit.sv]
// Top level of the sorted range table: sequencer, entry RAM and comparator.
//
// Usage: a request beat (insert, delete, find, clear) is taken at a rising
// edge where start is high and busy is low. busy stays high until the
// result has been shown. The result beat sits on rsp for exactly one cycle
// with done high; the receiver cannot stall it and must take it then.
// Entries live in one RAM with a registered read port; the sequencer walks
// them in order, one entry per cycle through a single comparator, then
// moves entries one slot per cycle to open or close a gap.
// Flow: clear, and insert into a full table, go straight to the result;
// find, and a delete or insert that is rejected, end at the slot hit; an
// accepted insert moves the entries from that slot on up one slot, last
// first, and an accepted delete moves those behind the slot down one.
// One item at a time: the next beat is taken on the cycle after done. The
// RAM port doing one read and one write per cycle sets the pace.
// Reset empties the table (entry count zero) and returns to idle; RAM
// contents are not cleared, only slots below the count are ever used.
module sorted_range_table_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  srt_pkg::req_t  req,
    output logic           done,
    output srt_pkg::rsp_t  rsp
);

    localparam int CB = srt_pkg::COUNT_BITS;
    localparam int IB = srt_pkg::IDX_BITS;
    localparam logic [CB-1:0] ONE  = CB'(1);
    localparam logic [CB-1:0] TWO  = CB'(2);
    localparam logic [CB-1:0] FULL = CB'(srt_pkg::CAPACITY);

    srt_pkg::state_t  state_reg, state_next;
    logic [CB-1:0]    count_reg, count_next;
    logic [CB-1:0]    idx_reg, idx_next;
    logic [CB-1:0]    slot_reg, slot_next;
    srt_pkg::req_t    req_reg, req_next;
    srt_pkg::status_t status_reg, status_next;
    srt_pkg::entry_t  hit_reg, hit_next;

    logic             ram_we;
    logic [IB-1:0]    ram_waddr;
    logic [IB-1:0]    ram_raddr;
    srt_pkg::entry_t  ram_wdata;
    logic [$bits(srt_pkg::entry_t)-1:0] ram_rdata;
    srt_pkg::entry_t  rd_entry;
    srt_pkg::cmp_t    flags;

    logic             at_end;
    logic             walk_stop;
    logic             walk_exact;
    logic             find_hit;
    logic             find_miss;
    logic             is_insert;
    logic             is_delete;
    logic             is_find;

    assign rd_entry = srt_pkg::entry_t'(ram_rdata);

    // Entry storage
    srt_ram #(
        .WIDTH ($bits(srt_pkg::entry_t)),
        .DEPTH (srt_pkg::CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Comparator on the entry just read against the held key
    srt_cmp u_cmp (
        .e_start  (rd_entry.start),
        .e_length (rd_entry.length),
        .q_start  (req_reg.req_start),
        .q_length (req_reg.req_length),
        .flags    (flags)
    );

    // Walk decisions
    always_comb
    begin
        is_insert  = req_reg.req_type == srt_pkg::REQ_INSERT;
        is_delete  = req_reg.req_type == srt_pkg::REQ_DELETE;
        is_find    = req_reg.req_type == srt_pkg::REQ_FIND;
        at_end     = idx_reg == count_reg;
        walk_stop  = at_end || !flags.ahead;
        walk_exact = !at_end && flags.exact;
        find_miss  = at_end || flags.past;
        find_hit   = !find_miss && flags.covers;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (req.req_type == srt_pkg::REQ_CLEAR ||
                        (req.req_type == srt_pkg::REQ_INSERT && count_reg >= FULL))
                    begin
                        state_next = srt_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = srt_pkg::S_WALK;
                    end
                end
            end
            srt_pkg::S_WALK:
            begin
                if (is_find)
                begin
                    if (find_miss || find_hit)
                    begin
                        state_next = srt_pkg::S_DONE;
                    end
                end
                else if (walk_stop)
                begin
                    if (is_insert)
                    begin
                        priority if (walk_exact)
                            state_next = srt_pkg::S_DONE;
                        else if (idx_reg == count_reg)
                            state_next = srt_pkg::S_PLACE;
                        else
                            state_next = srt_pkg::S_PREP;
                    end
                    else
                    begin
                        state_next = walk_exact ? srt_pkg::S_PREP : srt_pkg::S_DONE;
                    end
                end
            end
            srt_pkg::S_PREP:
            begin
                if (is_delete && (idx_reg + ONE == count_reg))
                    state_next = srt_pkg::S_PLACE;
                else
                    state_next = srt_pkg::S_SHIFT;
            end
            srt_pkg::S_SHIFT:
            begin
                if (is_insert)
                begin
                    if (idx_reg - ONE == slot_reg)
                        state_next = srt_pkg::S_PLACE;
                end
                else if (idx_reg + TWO == count_reg)
                begin
                    state_next = srt_pkg::S_PLACE;
                end
            end
            srt_pkg::S_PLACE:
            begin
                state_next = srt_pkg::S_DONE;
            end
            srt_pkg::S_DONE:
            begin
                state_next = srt_pkg::S_IDLE;
            end
            default:
            begin
                state_next = srt_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath register updates
    always_comb
    begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        slot_next   = slot_reg;
        req_next    = req_reg;
        status_next = status_reg;
        hit_next    = hit_reg;
        unique case (state_reg)
            srt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    req_next    = req;
                    status_next = srt_pkg::ST_OK;
                    hit_next    = '0;
                    idx_next    = '0;
                    if (req.req_type == srt_pkg::REQ_CLEAR)
                        count_next = '0;
                    if (req.req_type == srt_pkg::REQ_INSERT && count_reg >= FULL)
                        status_next = srt_pkg::ST_FULL;
                end
            end
            srt_pkg::S_WALK:
            begin
                if (is_find)
                begin
                    priority if (find_miss)
                        status_next = srt_pkg::ST_NONE;
                    else if (find_hit)
                        hit_next = rd_entry;
                    else
                        idx_next = idx_reg + ONE;
                end
                else if (walk_stop)
                begin
                    slot_next = idx_reg;
                    if (is_insert)
                    begin
                        idx_next = count_reg;
                        if (walk_exact)
                            status_next = srt_pkg::ST_DUP;
                    end
                    else if (!walk_exact)
                    begin
                        status_next = srt_pkg::ST_NONE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + ONE;
                end
            end
            srt_pkg::S_SHIFT:
            begin
                idx_next = is_insert ? idx_reg - ONE : idx_reg + ONE;
            end
            srt_pkg::S_PLACE:
            begin
                count_next = is_insert ? count_reg + ONE : count_reg - ONE;
            end
            srt_pkg::S_PREP,
            srt_pkg::S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // RAM port control and handshake outputs
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg[IB-1:0];
        ram_wdata = rd_entry;
        ram_raddr = '0;
        unique case (state_reg)
            srt_pkg::S_IDLE:
            begin
                ram_raddr = '0;
            end
            srt_pkg::S_WALK:
            begin
                ram_raddr = CB'(idx_reg + ONE) >= FULL ? '0 : IB'(idx_reg + ONE);
            end
            srt_pkg::S_PREP:
            begin
                ram_raddr = is_insert ? IB'(count_reg - ONE) : IB'(idx_reg + ONE);
            end
            srt_pkg::S_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_raddr = is_insert ? IB'(idx_reg - TWO) : IB'(idx_reg + TWO);
            end
            srt_pkg::S_PLACE:
            begin
                ram_we    = is_insert;
                ram_waddr = slot_reg[IB-1:0];
                ram_wdata = '{start:  req_reg.req_start,
                              length: req_reg.req_length,
                              handle: req_reg.req_handle};
            end
            srt_pkg::S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign busy = state_reg != srt_pkg::S_IDLE;
    assign done = state_reg == srt_pkg::S_DONE;

    // Result beat
    assign rsp = '{status:       status_reg,
                   found_handle: hit_reg.handle,
                   found_start:  hit_reg.start,
                   found_length: hit_reg.length,
                   entry_count:  count_reg};

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srt_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Payload and walk registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        slot_reg   <= slot_next;
        req_reg    <= req_next;
        status_reg <= status_next;
        hit_reg    <= hit_next;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("entry count above capacity");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg == srt_pkg::ST_FULL) |-> count_reg == FULL)
        else $error("full reported on a table with room");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == srt_pkg::S_SHIFT || state_reg == srt_pkg::S_PLACE))
        else $error("RAM write outside shift or place");

    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held past one cycle");
`endif

endmodule

[sv/srt_ram.sv]
// Generic simple dual-port RAM with registered read.
module srt_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 64
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [$clog2(DEPTH)-1:0]  waddr,
    input  logic [WIDTH-1:0]          wdata,
    input  logic [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/srt_cmp.sv]
// Shared comparator: orders one entry against the key and tests coverage.
module srt_cmp (
    input  logic [srt_pkg::OFFSET_BITS-1:0] e_start,
    input  logic [srt_pkg::OFFSET_BITS-1:0] e_length,
    input  logic [srt_pkg::OFFSET_BITS-1:0] q_start,
    input  logic [srt_pkg::OFFSET_BITS-1:0] q_length,
    output srt_pkg::cmp_t                   flags
);

    logic [srt_pkg::OFFSET_BITS-1:0] gap;
    logic [srt_pkg::OFFSET_BITS:0]   reach;

    // Distance into the entry plus query length, one guard bit so it never wraps
    assign gap   = q_start - e_start;
    assign reach = {1'b0, gap} + {1'b0, q_length};

    always_comb
    begin
        flags.past   = e_start > q_start;
        flags.exact  = (e_start == q_start) && (e_length == q_length);
        flags.ahead  = (e_start != q_start) ? (e_start < q_start) : (e_length > q_length);
        flags.covers = !flags.past && (reach <= {1'b0, e_length});
    end

endmodule
